// File: rtl/core/frwm_pkg.sv
package frwm_pkg;

  // Field widths of the channels and the configuration port.
  localparam int TS_W       = 64;
  localparam int DELTA_W    = 32;
  localparam int RATE_W     = 48;
  localparam int FRAME_W    = 64;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // The window holds at most 127 intervals (7-bit size), so the sum fits in 39 bits.
  localparam int SUM_W  = DELTA_W + CNT_W;
  // Nanoseconds per second needs 30 bits; count * 1e9 needs 37 bits.
  localparam int NS_W   = 30;
  localparam int NUM_W  = NS_W + CNT_W;
  // Dividend is count * 1e9 scaled by 2^16 for the Q.16 fraction.
  localparam int FRAC_W = 16;
  localparam int DVD_W  = NUM_W + FRAC_W;
  localparam int STEP_W = $clog2(DVD_W);

  localparam logic [NS_W-1:0]    NS_PER_SEC    = NS_W'(1000000000);
  localparam logic [DELTA_W-1:0] MAX_DELTA_RST = DELTA_W'(250000000);
  localparam logic [CNT_W-1:0]   WIN_SIZE_RST  = CNT_W'(60);
  localparam int                 WINDOW_MAX_DEF = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELTA   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_UPDATE,
    ST_DIV_INIT,
    ST_DIV,
    ST_EMIT
  } frwm_state_t;

  typedef struct packed {
    logic accept;
    logic clamp;
    logic update;
    logic div_init;
    logic div_step;
    logic load_out;
  } frwm_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } frwm_sts_t;

endpackage

// File: rtl/core/frwm_in_if.sv
interface frwm_in_if;
  logic                       valid;
  logic                       ready;
  logic [frwm_pkg::TS_W-1:0]  timestamp_ns;

  modport source (output valid, output timestamp_ns, input ready);
  modport sink   (input valid, input timestamp_ns, output ready);
endinterface

// File: rtl/core/frwm_out_if.sv
interface frwm_out_if;
  logic                          valid;
  logic                          ready;
  logic [frwm_pkg::DELTA_W-1:0]  delta_ns;
  logic [frwm_pkg::RATE_W-1:0]   rate_q16;
  logic [frwm_pkg::FRAME_W-1:0]  frame_number;
  logic [frwm_pkg::CNT_W-1:0]    filled_count;

  modport source (output valid, output delta_ns, output rate_q16, output frame_number,
                  output filled_count, input ready);
  modport sink   (input valid, input delta_ns, input rate_q16, input frame_number,
                  input filled_count, output ready);
endinterface

// File: rtl/core/frame_rate_window_meter.sv
// Channel   Dir  Handshake            Beat contents
// in_ch     in   valid / ready        timestamp_ns (64 bits)
// out_ch    out  valid / ready        delta_ns, rate_q16, frame_number, filled_count
// cfg_*     in   cfg_we, no wait      cfg_index selects max_delta_ns or window_size
//
// After its beat is accepted, a result passes these steps: the interval subtract is
// registered at the accepting edge, then come the clamp, the window update, the
// divider load, the bit-serial restoring divider and the output load. The controller
// then returns to idle and takes no new beat until that result has been loaded.
// Reset is synchronous and active low; it empties the window and restores the
// register defaults. The ring memory itself is not cleared.
// A finished result waits in the output register while the next input beat is
// accepted; the controller holds in its emit state only while that register is full.

module frame_rate_window_meter #(
  parameter int WINDOW_MAX = frwm_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  frwm_in_if.sink                           in_ch,
  frwm_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [frwm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [frwm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import frwm_pkg::*;

  // The controller sequences the steps of one frame; the datapath holds the window,
  // the ring memory, the divider and the output register.
  frwm_cmd_t cmd;
  frwm_sts_t sts;

  frwm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // The rate is floor(count * 1e9 * 2^16 / sum), saturated to 48 bits, and zero
  // when every interval in the window is zero.
  frwm_dp #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_timestamp_ns  (in_ch.timestamp_ns),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_delta_ns     (out_ch.delta_ns),
    .out_rate_q16     (out_ch.rate_q16),
    .out_frame_number (out_ch.frame_number),
    .out_filled_count (out_ch.filled_count)
  );

endmodule

// File: rtl/core/frwm_ram.sv
module frwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/frwm_ctrl.sv
module frwm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output frwm_pkg::frwm_cmd_t cmd,
  input  frwm_pkg::frwm_sts_t sts
);
  import frwm_pkg::*;

  frwm_state_t state_r;
  frwm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == ST_CLAMP)
    else $error("accepted beat did not start the clamp step");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && sts.div_last) |=> state_r == ST_EMIT)
    else $error("divider finished but no result was emitted");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.clamp, cmd.update, cmd.div_init, cmd.div_step, cmd.load_out}))
    else $error("more than one datapath command at once");

endmodule

// File: rtl/core/frwm_dp.sv
module frwm_dp #(
  parameter int WINDOW_MAX = frwm_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [frwm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [frwm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [frwm_pkg::TS_W-1:0]         in_timestamp_ns,
  input  frwm_pkg::frwm_cmd_t               cmd,
  output frwm_pkg::frwm_sts_t               sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [frwm_pkg::DELTA_W-1:0]      out_delta_ns,
  output logic [frwm_pkg::RATE_W-1:0]       out_rate_q16,
  output logic [frwm_pkg::FRAME_W-1:0]      out_frame_number,
  output logic [frwm_pkg::CNT_W-1:0]        out_filled_count
);
  import frwm_pkg::*;

  localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  // Zero is taken as one; sizes above the ring depth saturate.
  function automatic logic [CNT_W-1:0] clamp_ws(input logic [CNT_W-1:0] w);
    logic [CNT_W-1:0] res;
    res = w;
    if (w == '0) begin
      res = CNT_W'(1);
    end else if (int'(w) > WINDOW_MAX) begin
      res = CNT_W'(WINDOW_MAX);
    end
    return res;
  endfunction

  // Configuration and window state.
  logic [DELTA_W-1:0] max_r;
  logic [CNT_W-1:0]   ws_r;
  logic [TS_W-1:0]    prev_r;
  logic [SUM_W-1:0]   sum_r;
  logic [PTR_W-1:0]   cursor_r;
  logic [CNT_W-1:0]   held_r;
  logic [FRAME_W-1:0] frames_r;

  // Per-item working registers.
  logic [TS_W-1:0]    diff_r;
  logic [DELTA_W-1:0] delta_r;
  logic [SUM_W-1:0]   part_r;
  logic [NUM_W-1:0]   num_r;
  logic [DVD_W-1:0]   dvd_r;
  logic [DVD_W-1:0]   quo_r;
  logic [SUM_W-1:0]   rem_r;
  logic [STEP_W-1:0]  step_r;
  logic               zero_r;

  logic               out_valid_r;
  logic [DELTA_W-1:0] out_delta_r;
  logic [RATE_W-1:0]  out_rate_r;
  logic [FRAME_W-1:0] out_frame_r;
  logic [CNT_W-1:0]   out_count_r;

  logic [TS_W:0]      sub_ext;
  logic               full;
  logic [CNT_W-1:0]   held_nxt;
  logic [PTR_W-1:0]   cursor_nxt;
  logic [SUM_W:0]     trial;
  logic [DELTA_W-1:0] ring_rdata;
  logic [RATE_W-1:0]  rate_val;

  assign sub_ext  = {1'b0, in_timestamp_ns} - {1'b0, prev_r};
  assign full     = (held_r >= ws_r);
  assign held_nxt = full ? held_r : held_r + CNT_W'(1);
  assign cursor_nxt = (int'(cursor_r) + 1 >= int'(ws_r)) ? '0 : cursor_r + PTR_W'(1);
  assign trial    = {rem_r, dvd_r[DVD_W-1]} - {1'b0, sum_r};

  always_comb begin
    if (zero_r) begin
      rate_val = '0;
    end else if (|quo_r[DVD_W-1:RATE_W]) begin
      rate_val = '1;
    end else begin
      rate_val = quo_r[RATE_W-1:0];
    end
  end

  frwm_ram #(
    .WIDTH (DELTA_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (cursor_r),
    .wdata (delta_r),
    .raddr (cursor_r),
    .rdata (ring_rdata)
  );

  // Window state, configuration and the output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= MAX_DELTA_RST;
      ws_r        <= clamp_ws(WIN_SIZE_RST);
      prev_r      <= '0;
      sum_r       <= '0;
      cursor_r    <= '0;
      held_r      <= '0;
      frames_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_DELTA: begin
            max_r <= cfg_wdata[DELTA_W-1:0];
          end
          REG_WINDOW_SIZE: begin
            ws_r     <= clamp_ws(cfg_wdata[CNT_W-1:0]);
            sum_r    <= '0;
            cursor_r <= '0;
            held_r   <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.accept) begin
        prev_r <= in_timestamp_ns;
      end
      if (cmd.update) begin
        sum_r    <= part_r + SUM_W'(delta_r);
        held_r   <= held_nxt;
        cursor_r <= cursor_nxt;
        frames_r <= frames_r + FRAME_W'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers of the item in flight, the divider and the output payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      diff_r <= sub_ext[TS_W] ? '0 : sub_ext[TS_W-1:0];
    end
    if (cmd.clamp) begin
      delta_r <= (diff_r > TS_W'(max_r)) ? max_r : diff_r[DELTA_W-1:0];
      part_r  <= full ? sum_r - SUM_W'(ring_rdata) : sum_r;
    end
    if (cmd.update) begin
      num_r <= NUM_W'(held_nxt) * NUM_W'(NS_PER_SEC);
    end
    if (cmd.div_init) begin
      dvd_r  <= {num_r, FRAC_W'(0)};
      quo_r  <= '0;
      rem_r  <= '0;
      step_r <= STEP_W'(DVD_W - 1);
      zero_r <= (sum_r == '0);
    end
    if (cmd.div_step) begin
      dvd_r  <= {dvd_r[DVD_W-2:0], 1'b0};
      step_r <= step_r - STEP_W'(1);
      if (trial[SUM_W]) begin
        rem_r <= {rem_r[SUM_W-2:0], dvd_r[DVD_W-1]};
        quo_r <= {quo_r[DVD_W-2:0], 1'b0};
      end else begin
        rem_r <= trial[SUM_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], 1'b1};
      end
    end
    if (cmd.load_out) begin
      out_delta_r <= delta_r;
      out_rate_r  <= rate_val;
      out_frame_r <= frames_r;
      out_count_r <= held_r;
    end
  end

  assign sts.div_last = (step_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_delta_ns     = out_delta_r;
  assign out_rate_q16     = out_rate_r;
  assign out_frame_number = out_frame_r;
  assign out_filled_count = out_count_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= ws_r)
    else $error("window holds more intervals than its size");

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cursor_r) < int'(ws_r))
    else $error("ring cursor left the window");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r == '0) |-> (sum_r == '0))
    else $error("empty window with a nonzero sum");

endmodule

// File: tb/frame_rate_window_meter_tb.sv
`timescale 1ns / 1ps

module frame_rate_window_meter_tb;
  import frwm_pkg::*;

  // The block is built with its default window depth, so the predictor uses the same.
  localparam int WINDOW_LIMIT = WINDOW_MAX_DEF;
  localparam logic [RATE_W-1:0] RATE_CEILING = '1;
  // 1e9 ns per second times 2^16 for the Q.16 fraction.
  localparam logic [63:0] RATE_SCALE = 64'd65_536_000_000_000;
  // Indexes that decode to no register; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
  // Receiver hold-off long enough to fill the output register and the pipeline.
  localparam int LONG_HOLD = 500;
  localparam int RANDOM_PHASES = 8;
  localparam int BEATS_PER_PHASE = 100;

  // One result beat as it leaves the block.
  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic [RATE_W-1:0]  rate;
    logic [FRAME_W-1:0] frame;
    logic [CNT_W-1:0]   filled;
  } frame_stats_t;

  // Tracks the meter's window, predicts one result per accepted timestamp and
  // checks result beats in order against those predictions.
  class frame_stats_board;
    logic [DELTA_W-1:0] clamp_ns;
    int unsigned        window_len;
    logic [TS_W-1:0]    last_stamp;
    logic [DELTA_W-1:0] intervals [WINDOW_LIMIT];
    logic [SUM_W-1:0]   interval_total;
    int unsigned        cursor;
    int unsigned        held;
    logic [FRAME_W-1:0] frame_count;
    frame_stats_t       expected_frames[$];
    int unsigned        error_count;

    function new();
      clamp_ns    = MAX_DELTA_RST;
      window_len  = WIN_SIZE_RST;
      last_stamp  = '0;
      frame_count = '0;
      error_count = 0;
      clear_window();
    endfunction

    function void clear_window();
      foreach (intervals[i]) intervals[i] = '0;
      interval_total = '0;
      cursor = 0;
      held = 0;
    endfunction

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      int unsigned size;
      if (idx == REG_MAX_DELTA) begin
        clamp_ns = data[DELTA_W-1:0];
      end else if (idx == REG_WINDOW_SIZE) begin
        size = data[CNT_W-1:0];
        if (size < 1) size = 1;
        if (size > WINDOW_LIMIT) size = WINDOW_LIMIT;
        window_len = size;
        clear_window();
      end
    endfunction

    function logic [RATE_W-1:0] window_rate(int unsigned count, logic [SUM_W-1:0] total);
      logic [63:0] quotient;
      if (total == '0) return '0;
      quotient = (64'(count) * RATE_SCALE) / 64'(total);
      if (quotient > 64'(RATE_CEILING)) return RATE_CEILING;
      return quotient[RATE_W-1:0];
    endfunction

    function void predict_frame(logic [TS_W-1:0] stamp);
      logic [TS_W-1:0]    diff;
      logic [DELTA_W-1:0] delta;
      int unsigned        slot;
      frame_stats_t       want;
      diff = (stamp >= last_stamp) ? stamp - last_stamp : '0;
      last_stamp = stamp;
      delta = (diff > TS_W'(clamp_ns)) ? clamp_ns : diff[DELTA_W-1:0];
      slot = (cursor >= WINDOW_LIMIT) ? 0 : cursor;
      if (held < window_len) held++;
      else interval_total -= SUM_W'(intervals[slot]);
      intervals[slot] = delta;
      interval_total += SUM_W'(delta);
      cursor = (slot + 1 >= window_len) ? 0 : slot + 1;
      frame_count++;
      want.delta  = delta;
      want.rate   = window_rate(held, interval_total);
      want.frame  = frame_count;
      want.filled = CNT_W'(held);
      expected_frames.push_back(want);
    endfunction

    function int unsigned pending();
      return expected_frames.size();
    endfunction

    task report_mismatch(string what);
      error_count++;
      if (error_count <= 50) $display("ERROR @%0t: %s", $realtime, what);
    endtask

    task check_frame(frame_stats_t got);
      frame_stats_t want;
      if (expected_frames.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing outstanding, frame_number %0d",
                                  got.frame));
        return;
      end
      want = expected_frames.pop_front();
      if (got.delta !== want.delta)
        report_mismatch($sformatf("frame %0d delta_ns got %0d want %0d",
                                  want.frame, got.delta, want.delta));
      if (got.rate !== want.rate)
        report_mismatch($sformatf("frame %0d rate_q16 got %0h want %0h",
                                  want.frame, got.rate, want.rate));
      if (got.frame !== want.frame)
        report_mismatch($sformatf("frame_number got %0d want %0d", got.frame, want.frame));
      if (got.filled !== want.filled)
        report_mismatch($sformatf("frame %0d filled_count got %0d want %0d",
                                  want.frame, got.filled, want.filled));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  frwm_in_if  in_ch ();
  frwm_out_if out_ch ();

  frame_stats_board board = new();

  // Set by the stimulus to ask the receiver for one long hold-off; the receiver
  // clears it when it starts counting.
  bit hold_request = 1'b0;

  // Last timestamp offered, used only to build the next one.
  logic [TS_W-1:0] gen_last = '0;
  // Beats left in the current sender burst.
  int unsigned burst_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  frame_rate_window_meter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Offer one timestamp beat and hold it until the block takes it. The prediction
  // is made here, at the accepting edge, so it is in place before anyone asks
  // whether results are still outstanding.
  task automatic send_frame(input logic [TS_W-1:0] stamp);
    in_ch.valid        <= 1'b1;
    in_ch.timestamp_ns <= stamp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.predict_frame(stamp);
    gen_last = stamp;
  endtask

  // Bursts of random length separated by random gaps. A zero gap lets two bursts
  // run together, which gives long stretches with valid held high.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Stop offering beats and wait until every predicted result has been seen.
  // Every timestamp yields a result, so once the queue is empty the block is idle;
  // a few spare cycles keep register writes clear of the last output beat.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write, after which the write enable is driven low again so that
  // back-to-back writes never assign cfg_we twice in one step.
  task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    board.apply_register(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Window size writes carry random upper bits; only the low seven count.
  task automatic program_window(input int unsigned size);
    program_register(REG_WINDOW_SIZE, {25'($urandom), CNT_W'(size)});
  endtask

  // Pick a new operating point for a random phase, extremes included.
  task automatic pick_settings();
    case ($urandom_range(0, 5))
      0: program_register(REG_MAX_DELTA, '0);
      1: program_register(REG_MAX_DELTA, '1);
      2: program_register(REG_MAX_DELTA, $urandom);
      3: program_register(REG_MAX_DELTA, $urandom_range(1, 1000));
      4: program_register(REG_MAX_DELTA, $urandom_range(1_000_000, 100_000_000));
      default: ;
    endcase
    case ($urandom_range(0, 4))
      0: program_window(1);
      1: program_window(WINDOW_LIMIT);
      2: program_window($urandom_range(0, 127));
      3: program_window($urandom_range(1, 8));
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0)
      program_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
  endtask

  // Mostly a forward-running clock with intervals on several scales, plus repeats
  // (zero intervals, which drive the rate to saturation or to a zero sum), steps
  // backwards, and fully random stamps that can land anywhere in 64 bits.
  function automatic logic [TS_W-1:0] next_stamp();
    logic [TS_W-1:0] step;
    int unsigned     pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      case ($urandom_range(0, 4))
        0: step = $urandom_range(0, 300);
        1: step = $urandom_range(1000, 2_000_000);
        2: step = $urandom_range(5_000_000, 60_000_000);
        3: step = $urandom;
        default: step = {$urandom, $urandom} >> $urandom_range(20, 40);
      endcase
      return gen_last + step;
    end
    if (pick < 70) return gen_last;
    if (pick < 85) return gen_last + 64'd16_665_667 + $urandom_range(0, 2000);
    if (pick < 93) return gen_last - $urandom_range(1, 1000);
    return {$urandom, $urandom};
  endfunction

  // Receiver: switches between stall patterns at random intervals, and on
  // request holds ready low for a long stretch that it counts itself.
  initial begin : receiver
    int unsigned pattern;
    int unsigned pattern_left;
    int unsigned tick;
    pattern = 0;
    pattern_left = 0;
    tick = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        if (pattern_left == 0) begin
          pattern = $urandom_range(0, 3);
          pattern_left = $urandom_range(20, 400);
        end
        pattern_left--;
        tick++;
        case (pattern)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= (tick % 4 == 0);
          default: out_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Every output beat taken is checked against the oldest prediction.
  always @(posedge clk) begin
    frame_stats_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.delta  = out_ch.delta_ns;
      got.rate   = out_ch.rate_q16;
      got.frame  = out_ch.frame_number;
      got.filled = out_ch.filled_count;
      board.check_frame(got);
    end
  end

  initial begin : stimulus
    int unsigned phase_idx;
    int unsigned beat_idx;
    bit          drain_mid;

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.timestamp_ns <= '0;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_wdata          <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: the first interval is measured from time zero, a repeated
    // stamp gives a zero interval, backward steps give zero, and long gaps clamp.
    send_frame(64'd16_666_667);
    send_frame(64'd33_333_334);
    send_frame(64'd33_333_334);
    send_frame(64'd1000);
    send_frame(64'd300_001_000);
    send_frame('1);
    send_frame('0);
    settle();

    // Writes to undecoded indexes must leave both registers alone. Then a zero
    // clamp and a zero window size (taken as one), which also empties the window:
    // every interval is zero, so the sum is zero and so is the rate.
    program_register(REG_SPARE_A, $urandom);
    program_register(REG_SPARE_B, $urandom);
    program_register(REG_MAX_DELTA, '0);
    program_window(0);
    send_frame(64'd5);
    send_frame(64'd10);
    send_frame(64'd10);
    settle();

    // Widest clamp and an oversized window, which saturates to the maximum. One
    // nanosecond followed by repeats packs many entries onto a tiny sum, which
    // drives the rate into saturation. Then clamps at the full 32 bits and a
    // backward step from the top half of the range.
    program_register(REG_MAX_DELTA, '1);
    program_window(127);
    send_frame(64'd11);
    repeat (5) send_frame(64'd11);
    send_frame(64'd11 + 64'h1_0000_0005);
    send_frame(64'h8000_0000_0000_0000);
    send_frame(64'h7FFF_FFFF_FFFF_FFFF);
    settle();

    // Just above the largest window size, with the reset clamp restored.
    program_register(REG_MAX_DELTA, MAX_DELTA_RST);
    program_window(WINDOW_LIMIT + 1);
    send_frame(gen_last + 64'd1_000_000);
    send_frame(gen_last + 64'd16_666_667);
    send_frame(gen_last + 64'd8_333_333);
    settle();

    // Random phases, each at its own settings.
    for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
      pick_settings();
      drain_mid = (phase_idx % 3 == 2) || ($urandom_range(0, 3) == 0);
      for (beat_idx = 0; beat_idx < BEATS_PER_PHASE; beat_idx++) begin
        // Long receiver hold-off with the sender offering beats back to back, so
        // the output register fills and the block stops taking input.
        if (beat_idx == 40 && phase_idx % 3 == 1) begin
          hold_request = 1'b1;
          repeat (12) send_frame(next_stamp());
        end
        // Sender pause until every outstanding result is back.
        if (beat_idx == 70 && drain_mid) settle();
        pace_sender();
        send_frame(next_stamp());
      end
      settle();
    end

    // Any stray result beat after the last prediction still gets caught here.
    repeat (100) @(posedge clk);
    if (board.error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #2_400_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/frwm_pkg.sv
rtl/core/frwm_in_if.sv
rtl/core/frwm_out_if.sv
rtl/core/frwm_ram.sv
rtl/core/frwm_ctrl.sv
rtl/core/frwm_dp.sv
rtl/core/frame_rate_window_meter.sv
tb/frame_rate_window_meter_tb.sv
